>>> design/pot_median_ema_color_conditioner_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the potentiometer conditioner
// Immediate-implication and next-cycle-implication checks with async reset.
// ----------------------------------------------------------------------------
`ifndef POT_MEDIAN_EMA_COLOR_CONDITIONER_DEFINES_SVH
`define POT_MEDIAN_EMA_COLOR_CONDITIONER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMC_ASSERT_IMPL(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pmc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PMC_ASSERT_NEXT(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pmc: next-cycle check failed");

`endif

>>> design/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types and constants of the potentiometer conditioner.
// ----------------------------------------------------------------------------
package pmc_pkg;

	localparam int NUM_CH    = 5;
	localparam int NUM_COLOR = 4;
	localparam int CH_W      = 3;
	localparam int SAMPLE_W  = 12;
	localparam int LVL_W     = 8;
	localparam int SCALED_W  = SAMPLE_W + LVL_W;
	localparam int WSUM_W    = 12;
	localparam int PROD_W    = 2 * LVL_W;

	localparam int CH_RED    = 0;
	localparam int CH_GREEN  = 1;
	localparam int CH_BLUE   = 2;
	localparam int CH_WHITE  = 3;
	localparam logic [CH_W-1:0] CH_BRIGHT = 3'd4;

	localparam int Q_DEPTH = 2;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_HYST  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 4'd1;

	localparam logic [7:0] HYST_RESET  = 8'd2;
	localparam logic [3:0] ALPHA_RESET = 4'd2;
	localparam logic [3:0] W_MAX       = 4'd10;

	// Exact reciprocal multipliers: floor(v/10) for v < 2^12, floor(v/255) for v < 2^16.
	localparam int DIV10_MUL_W  = 13;
	localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 13'd6554;
	localparam int DIV10_SHIFT  = 16;
	localparam int DIV255_MUL_W = 17;
	localparam logic [DIV255_MUL_W-1:0] DIV255_MUL = 17'd65794;
	localparam int DIV255_SHIFT = 24;

	typedef logic [LVL_W-1:0] level_t;

	typedef struct packed {
		logic [CH_W-1:0]     ch;
		logic [SCALED_W-1:0] scaled;
	} item_t;

	typedef struct packed {
		level_t [NUM_CH-1:0]    level;
		level_t [NUM_COLOR-1:0] drive;
		logic                   changed;
	} result_t;

endpackage

>>> design/pmc_front.sv
// ----------------------------------------------------------------------------
// pmc_front
// Takes requests, drops unused channel codes, forms the clamped median
// times 255 and hands it to the queue.
// ----------------------------------------------------------------------------
module pmc_front
	import pmc_pkg::*;
#(
	parameter int unsigned SAMPLE_MAX = 4095
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [CH_W-1:0]     channel,
	input  logic [SAMPLE_W-1:0] sample_a,
	input  logic [SAMPLE_W-1:0] sample_b,
	input  logic [SAMPLE_W-1:0] sample_c,
	output logic                q_push,
	output item_t               q_item,
	input  logic                q_full
);

	localparam logic [16:0] SMAX = 17'(SAMPLE_MAX);

	function automatic logic [SAMPLE_W-1:0] median3(input logic [SAMPLE_W-1:0] x,
		input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] z);
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		lo = (x < y) ? x : y;
		hi = (x < y) ? y : x;
		return (z >= hi) ? hi : ((z <= lo) ? lo : z);
	endfunction

	logic                v_s1;
	item_t               item_s1;
	logic                accept;
	logic [SAMPLE_W-1:0] med;
	logic [SAMPLE_W-1:0] raw;
	logic [SCALED_W-1:0] scaled;

	assign accept = push && !full;
	assign full   = v_s1 && q_full;
	assign q_push = v_s1;
	assign q_item = item_s1;

	always_comb begin
		med    = median3(sample_a, sample_b, sample_c);
		raw    = (17'(med) > SMAX) ? SMAX[SAMPLE_W-1:0] : med;
		scaled = {raw, LVL_W'(0)} - SCALED_W'(raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= (channel < CH_W'(NUM_CH));
		end else if (v_s1 && !q_full) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.ch     <= channel;
			item_s1.scaled <= scaled;
		end
	end

endmodule

>>> design/pmc_queue.sv
// ----------------------------------------------------------------------------
// pmc_queue
// Short FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "pot_median_ema_color_conditioner_defines.svh"

module pmc_queue
	import pmc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd,
	output logic  rd_valid,
	output item_t rd_item
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	item_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign full     = (count_q == CNT_W'(Q_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rptr_q];
	assign do_wr    = wr && !full;
	assign do_rd    = rd && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	`PMC_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(Q_DEPTH))
	`PMC_ASSERT_NEXT(a_count_grows, clk, arst_n, do_wr && !do_rd, count_q == CNT_W'($past(count_q) + 1'b1))

endmodule

>>> design/pmc_back.sv
// ----------------------------------------------------------------------------
// pmc_back
// Sequencer that maps a request to a level, updates the channel average and,
// on a brightness request, builds the drive values and the result.
// ----------------------------------------------------------------------------
`include "pot_median_ema_color_conditioner_defines.svh"

module pmc_back
	import pmc_pkg::*;
#(
	parameter int unsigned SAMPLE_MAX = 4095
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       q_pop,
	input  logic [7:0] hysteresis,
	input  logic [3:0] alpha_weight,
	input  logic       pop,
	output logic       empty,
	output result_t    result
);

	// floor(x / SAMPLE_MAX) as (x * LVL_MUL) >> LVL_SHIFT, exact for x < 2^SCALED_W.
	localparam int LVL_L     = $clog2(SAMPLE_MAX);
	localparam int LVL_SHIFT = SCALED_W + LVL_L;
	localparam int LVL_MUL_W = SCALED_W + 1;
	localparam logic [63:0] LVL_MUL_FULL =
		((64'd1 << LVL_SHIFT) + 64'(SAMPLE_MAX) - 64'd1) / 64'(SAMPLE_MAX);
	localparam logic [LVL_MUL_W-1:0] LVL_MUL = LVL_MUL_FULL[LVL_MUL_W-1:0];
	localparam int LVL_PW    = LVL_SHIFT + LVL_W;
	localparam int DIV10_PW  = WSUM_W + DIV10_MUL_W;
	localparam int DIV255_PW = PROD_W + DIV255_MUL_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_MIX,
		ST_DIV,
		ST_DRIVE,
		ST_PUBLISH
	} state_t;

	state_t                  state_q;
	logic [CH_W-1:0]         ch_q;
	logic [SCALED_W-1:0]     scaled_q;
	level_t                  lvl_q;
	logic [WSUM_W-1:0]       wsum_q;
	logic [CH_W-1:0]         idx_q;
	logic [PROD_W-1:0]       prod_s1;
	level_t [NUM_CH-1:0]     avg_q;
	level_t [NUM_CH-1:0]     stored_q;
	level_t [NUM_COLOR-1:0]  drive_q;
	logic                    stored_valid_q;
	logic                    res_valid_q;
	result_t                 res_q;

	logic [LVL_PW-1:0]       lvl_prod;
	level_t                  lvl_new;
	logic [3:0]              w;
	logic [3:0]              inv_w;
	logic [CH_W-1:0]         rd_addr;
	level_t                  rd_avg;
	level_t                  seed;
	logic [WSUM_W-1:0]       wsum;
	logic [DIV10_PW-1:0]     div10_prod;
	level_t                  avg_new;
	logic [PROD_W-1:0]       br_prod;
	logic [DIV255_PW-1:0]    div255_prod;
	level_t                  drive_new;
	logic [1:0]              drive_idx;
	logic [NUM_CH-1:0]       moved;
	logic                    chg;
	logic                    load;

	always_comb begin
		lvl_prod = LVL_PW'(scaled_q) * LVL_PW'(LVL_MUL);
		lvl_new  = 8'd255 - lvl_prod[LVL_SHIFT +: LVL_W];

		w       = (alpha_weight > W_MAX) ? W_MAX : alpha_weight;
		inv_w   = W_MAX - w;
		rd_addr = (state_q == ST_DRIVE) ? idx_q : ch_q;
		rd_avg  = avg_q[rd_addr];
		// A zero average is seeded with the new level before blending.
		seed    = (rd_avg == '0) ? lvl_q : rd_avg;
		wsum    = WSUM_W'(seed) * WSUM_W'(inv_w) + WSUM_W'(lvl_q) * WSUM_W'(w);

		div10_prod = DIV10_PW'(wsum_q) * DIV10_PW'(DIV10_MUL);
		avg_new    = div10_prod[DIV10_SHIFT +: LVL_W];

		br_prod     = PROD_W'(rd_avg) * PROD_W'(avg_q[CH_BRIGHT]);
		div255_prod = DIV255_PW'(prod_s1) * DIV255_PW'(DIV255_MUL);
		drive_new   = div255_prod[DIV255_SHIFT +: LVL_W];
		drive_idx   = 2'(idx_q - 1'b1);

		for (int i = 0; i < NUM_CH; i++) begin
			moved[i] = (avg_q[i] > stored_q[i]) ?
				((avg_q[i] - stored_q[i]) >= hysteresis) :
				((stored_q[i] - avg_q[i]) >= hysteresis);
		end
		chg  = !stored_valid_q || (moved != '0);
		load = (state_q == ST_PUBLISH) && (!res_valid_q || pop);
	end

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign empty  = !res_valid_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ch_q           <= '0;
			scaled_q       <= '0;
			lvl_q          <= '0;
			wsum_q         <= '0;
			idx_q          <= '0;
			prod_s1        <= '0;
			avg_q          <= '0;
			stored_q       <= '0;
			drive_q        <= '0;
			stored_valid_q <= 1'b0;
			res_valid_q    <= 1'b0;
			res_q          <= '0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						ch_q     <= q_item.ch;
						scaled_q <= q_item.scaled;
						state_q  <= ST_LEVEL;
					end
				end
				ST_LEVEL: begin
					lvl_q   <= lvl_new;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					wsum_q  <= wsum;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					avg_q[ch_q] <= avg_new;
					idx_q       <= '0;
					state_q     <= (ch_q == CH_BRIGHT) ? ST_DRIVE : ST_IDLE;
				end
				ST_DRIVE: begin
					// One product per cycle; the division by 255 works on the previous product, held in prod_s1.
					prod_s1 <= br_prod;
					if (idx_q != '0) begin
						drive_q[drive_idx] <= drive_new;
					end
					if (idx_q == CH_W'(NUM_COLOR)) begin
						state_q <= ST_PUBLISH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_PUBLISH: begin
					if (load) begin
						res_q.level   <= avg_q;
						res_q.drive   <= drive_q;
						res_q.changed <= chg;
						if (chg) begin
							stored_q       <= avg_q;
							stored_valid_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PMC_ASSERT_IMPL(a_drive_only_bright, clk, arst_n, state_q == ST_DRIVE, ch_q == CH_BRIGHT)
	`PMC_ASSERT_NEXT(a_stored_sticky, clk, arst_n, stored_valid_q, stored_valid_q)
	`PMC_ASSERT_IMPL(a_no_overwrite, clk, arst_n, load, !res_valid_q || pop)

endmodule

>>> design/pot_median_ema_color_conditioner.sv
// ----------------------------------------------------------------------------
// pot_median_ema_color_conditioner
// The back sequencer takes one request at a time. A color request runs through
// ST_LEVEL, ST_MIX and ST_DIV, where its average is updated; a brightness request
// also passes through ST_DRIVE and ST_PUBLISH, where a waiting result can hold it.
// Reset is asynchronous: averages and stored frame clear, hysteresis and weight return to 2.
// ----------------------------------------------------------------------------
module pot_median_ema_color_conditioner
	import pmc_pkg::*;
#(
	parameter int unsigned SAMPLE_MAX = 4095
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [CH_W-1:0]       channel,
	input  logic [SAMPLE_W-1:0]   sample_a,
	input  logic [SAMPLE_W-1:0]   sample_b,
	input  logic [SAMPLE_W-1:0]   sample_c,
	output logic                  empty,
	input  logic                  pop,
	output logic [LVL_W-1:0]      red_level,
	output logic [LVL_W-1:0]      green_level,
	output logic [LVL_W-1:0]      blue_level,
	output logic [LVL_W-1:0]      white_level,
	output logic [LVL_W-1:0]      bright_level,
	output logic [LVL_W-1:0]      red_drive,
	output logic [LVL_W-1:0]      green_drive,
	output logic [LVL_W-1:0]      blue_drive,
	output logic [LVL_W-1:0]      white_drive,
	output logic                  changed,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [7:0] hysteresis_q;
	logic [3:0] alpha_q;
	logic       q_push;
	item_t      q_wr_item;
	logic       q_full;
	logic       q_valid;
	item_t      q_rd_item;
	logic       q_pop;
	result_t    result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hysteresis_q <= HYST_RESET;
			alpha_q      <= ALPHA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HYST:  hysteresis_q <= cfg_data;
				REG_ALPHA: alpha_q      <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	pmc_front #(
		.SAMPLE_MAX(SAMPLE_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.channel  (channel),
		.sample_a (sample_a),
		.sample_b (sample_b),
		.sample_c (sample_c),
		.q_push   (q_push),
		.q_item   (q_wr_item),
		.q_full   (q_full)
	);

	pmc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_push),
		.wr_item  (q_wr_item),
		.full     (q_full),
		.rd       (q_pop),
		.rd_valid (q_valid),
		.rd_item  (q_rd_item)
	);

	pmc_back #(
		.SAMPLE_MAX(SAMPLE_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_rd_item),
		.q_pop        (q_pop),
		.hysteresis   (hysteresis_q),
		.alpha_weight (alpha_q),
		.pop          (pop),
		.empty        (empty),
		.result       (result)
	);

	assign red_level    = result.level[CH_RED];
	assign green_level  = result.level[CH_GREEN];
	assign blue_level   = result.level[CH_BLUE];
	assign white_level  = result.level[CH_WHITE];
	assign bright_level = result.level[CH_BRIGHT];
	assign red_drive    = result.drive[CH_RED];
	assign green_drive  = result.drive[CH_GREEN];
	assign blue_drive   = result.drive[CH_BLUE];
	assign white_drive  = result.drive[CH_WHITE];
	assign changed      = result.changed;

endmodule
